/* hw/rtl/vrt_pkg.sv */
// Shared types and constants for the voxel ray walker.
package vrt_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned TFracBits = 32;
  localparam int unsigned MaxJump   = 64;
  localparam int unsigned InBits    = 24;
  localparam int unsigned IntBits   = InBits - FracBits;
  localparam int unsigned TBits     = 64;
  localparam int unsigned CntBits   = 7;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrBits  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QFillBits = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpStep  = 2'd1,
    OpJump  = 2'd2,
    OpReset = 2'd3
  } op_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [TBits-1:0] tval_t;

  // One classified request handed from the front end to the walker.
  typedef struct packed {
    op_e                           op;
    logic signed [2:0][IntBits-1:0] s_int;
    logic signed [2:0][IntBits-1:0] e_int;
    logic [2:0][FracBits-1:0]      frac;
    logic [CntBits-1:0]            cnt;
  } req_t;

endpackage

/* hw/rtl/vrt_front.sv */
// Front end: accepts requests, splits coordinates, saturates count, queues.
module vrt_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic signed [23:0]         start_x_i,
  input  logic signed [23:0]         start_y_i,
  input  logic signed [23:0]         start_z_i,
  input  logic signed [23:0]         end_x_i,
  input  logic signed [23:0]         end_y_i,
  input  logic signed [23:0]         end_z_i,
  input  logic [6:0]                 count_i,
  output logic                       req_valid_o,
  input  logic                       req_ready_i,
  output vrt_pkg::req_t              req_o
);
  import vrt_pkg::*;

  req_t                 q_mem [QDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QFillBits-1:0] fill_q;
  req_t                 new_req;
  logic                 push, pop;

  // Classify the incoming request.
  always_comb begin
    new_req.op       = op_e'(op_i);
    new_req.s_int[0] = start_x_i[InBits-1:FracBits];
    new_req.s_int[1] = start_y_i[InBits-1:FracBits];
    new_req.s_int[2] = start_z_i[InBits-1:FracBits];
    new_req.e_int[0] = end_x_i[InBits-1:FracBits];
    new_req.e_int[1] = end_y_i[InBits-1:FracBits];
    new_req.e_int[2] = end_z_i[InBits-1:FracBits];
    new_req.frac[0]  = start_x_i[FracBits-1:0];
    new_req.frac[1]  = start_y_i[FracBits-1:0];
    new_req.frac[2]  = start_z_i[FracBits-1:0];
    new_req.cnt      = (count_i > CntBits'(MaxJump)) ? CntBits'(MaxJump) : count_i;
  end

  assign in_ready_o  = (fill_q != QFillBits'(QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign req_valid_o = (fill_q != '0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = q_mem[rd_ptr_q];

  // Store queued requests.
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= new_req;
  end

  // Advance queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrBits'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrBits'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrBits'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrBits'(1);
      end
      fill_q <= fill_q + QFillBits'(push) - QFillBits'(pop);
    end
  end
endmodule

/* hw/rtl/vrt_div.sv */
// Restoring divider: 64-bit quotient of num / den, one bit per cycle.
module vrt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;
  logic        ge;

  assign trial  = {rem_q[31:0], quo_q[63]};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == 7'd0);
  assign quo_o  = quo_q;

  // Shift in one quotient bit each cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= 33'd0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != 7'd0) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
    end
  end
endmodule

/* hw/rtl/vrt_walk.sv */
// Back end: holds the walker state, runs loads, steps, jumps and resets.
module vrt_walk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  vrt_pkg::req_t        req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [15:0]   voxel_x_o,
  output logic signed [15:0]   voxel_y_o,
  output logic signed [15:0]   voxel_z_o,
  output logic                 more_o
);
  import vrt_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDivStart, StDivWait, StJump, StOut
  } state_e;

  state_e              state_q;
  req_t                req_q;
  coord_t [2:0]        cur_q, goal_q;
  logic [2:0][1:0]     sgn_q;
  tval_t [2:0]         tmax_q, tdel_q;
  logic [1:0]          axis_q;
  logic                phase_q;
  logic [CntBits-1:0]  left_q;
  logic                moving_q;
  coord_t [2:0]        vox_q;
  logic                more_q;

  logic                at_goal;
  logic [1:0]          pick;
  logic [IntBits:0]    diff;
  logic [IntBits:0]    mag;
  logic [FracBits:0]   numer;
  logic [FracBits-1:0] fr;
  logic                div_start, div_done;
  logic [63:0]         div_num, div_quo;
  logic [31:0]         div_den;
  coord_t [2:0]        cur_adv;
  tval_t [2:0]         tmax_adv;
  tval_t               tsum;
  logic                tcarry;

  assign at_goal = (cur_q == goal_q);

  // Pick the axis with the least tmax; on a tie z wins, then y wins over x.
  always_comb begin
    if (tmax_q[0] < tmax_q[1]) pick = (tmax_q[0] < tmax_q[2]) ? 2'd0 : 2'd2;
    else                       pick = (tmax_q[1] < tmax_q[2]) ? 2'd1 : 2'd2;
  end

  // Move one cell along the chosen axis.
  always_comb begin
    cur_adv  = cur_q;
    tmax_adv = tmax_q;
    {tcarry, tsum} = {1'b0, tmax_q[pick]} + {1'b0, tdel_q[pick]};
    if (sgn_q[pick] == 2'b01) cur_adv[pick] = cur_q[pick] + coord_t'(1);
    if (sgn_q[pick] == 2'b11) cur_adv[pick] = cur_q[pick] - coord_t'(1);
    tmax_adv[pick] = tcarry ? '1 : tsum;
  end

  // Per-axis division operands for the load sequence.
  always_comb begin
    diff  = {req_q.e_int[axis_q][IntBits-1], req_q.e_int[axis_q]}
          - {req_q.s_int[axis_q][IntBits-1], req_q.s_int[axis_q]};
    mag   = diff[IntBits] ? -diff : diff;
    fr    = req_q.frac[axis_q];
    if (!diff[IntBits]) numer = (FracBits+1)'(1 << FracBits) - {1'b0, fr};
    else if (fr == '0)  numer = (FracBits+1)'(1 << FracBits);
    else                numer = {1'b0, fr};
    if (phase_q == 1'b0) begin
      div_num = 64'(numer) << TFracBits;
      div_den = 32'(mag) << FracBits;
    end else begin
      div_num = 64'd1 << TFracBits;
      div_den = 32'(mag);
    end
  end

  assign div_start = (state_q == StDivStart) && (diff != '0);

  vrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign req_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign voxel_x_o   = vox_q[0];
  assign voxel_y_o   = vox_q[1];
  assign voxel_z_o   = vox_q[2];
  assign more_o      = more_q;

  // Sequence each request and hold its result until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cur_q    <= '0;
      goal_q   <= '0;
      sgn_q    <= '0;
      tmax_q   <= '1;
      tdel_q   <= '1;
      axis_q   <= 2'd0;
      phase_q  <= 1'b0;
      left_q   <= '0;
      moving_q <= 1'b0;
      more_q   <= 1'b0;
      vox_q    <= '0;
      req_q    <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (req_valid_i) begin
            req_q <= req_i;
            unique case (req_i.op)
              OpLoad: begin
                for (int a = 0; a < 3; a++) begin
                  cur_q[a]  <= coord_t'(req_i.s_int[a]);
                  goal_q[a] <= coord_t'(req_i.e_int[a]);
                end
                sgn_q    <= '0;
                moving_q <= 1'b0;
                axis_q   <= 2'd0;
                phase_q  <= 1'b0;
                state_q  <= StDivStart;
              end
              OpStep: begin
                vox_q  <= cur_q;
                more_q <= !at_goal;
                if (!at_goal) begin
                  cur_q  <= cur_adv;
                  tmax_q <= tmax_adv;
                end
                state_q <= StOut;
              end
              OpJump: begin
                if (req_i.cnt == '0 || at_goal) begin
                  vox_q   <= cur_q;
                  more_q  <= 1'b0;
                  state_q <= StOut;
                end else begin
                  left_q  <= req_i.cnt;
                  state_q <= StJump;
                end
              end
              OpReset: begin
                for (int a = 0; a < 3; a++) begin
                  cur_q[a] <= coord_t'(req_i.s_int[a]);
                  if (sgn_q[a] != 2'b00) tmax_q[a] <= tval_t'(1) << TFracBits;
                end
                more_q  <= 1'b0;
                state_q <= StJump;
                left_q  <= '0;
              end
              default: state_q <= StIdle;
            endcase
          end
        end
        StDivStart: begin
          if (diff == '0) begin
            tmax_q[axis_q] <= '1;
            tdel_q[axis_q] <= '1;
            if (axis_q == 2'd2) begin
              vox_q   <= cur_q;
              more_q  <= moving_q;
              state_q <= StOut;
            end else axis_q <= axis_q + 2'd1;
          end else state_q <= StDivWait;
        end
        StDivWait: begin
          if (div_done) begin
            if (phase_q == 1'b0) begin
              tmax_q[axis_q] <= div_quo;
              phase_q        <= 1'b1;
              state_q        <= StDivStart;
            end else begin
              tdel_q[axis_q] <= div_quo;
              sgn_q[axis_q]  <= diff[IntBits] ? 2'b11 : 2'b01;
              moving_q       <= 1'b1;
              phase_q        <= 1'b0;
              if (axis_q == 2'd2) begin
                vox_q   <= cur_q;
                more_q  <= 1'b1;
                state_q <= StOut;
              end else begin
                axis_q  <= axis_q + 2'd1;
                state_q <= StDivStart;
              end
            end
          end
        end
        StJump: begin
          // A reset request passes here with no cells left to report.
          if (left_q == '0) begin
            vox_q   <= cur_q;
            more_q  <= !at_goal;
            state_q <= StOut;
          end else begin
            cur_q  <= cur_adv;
            tmax_q <= tmax_adv;
            left_q <= left_q - CntBits'(1);
            if (cur_adv == goal_q) begin
              vox_q   <= cur_adv;
              more_q  <= 1'b0;
              state_q <= StOut;
            end else if (left_q == CntBits'(1)) begin
              vox_q   <= cur_adv;
              more_q  <= 1'b1;
              state_q <= StOut;
            end
          end
        end
        StOut: begin
          if (out_ready_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

/* hw/rtl/voxel_ray_traversal.sv */
// Top level of the voxel ray walker: front end, queue and walker.
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, op_i..count_i      | request in
//  out     | out_valid_o/out_ready_i, voxel_*_o,more_o | result out
//
// From request to result, a step goes from idle straight to the output state,
// a reset passes the jump state first, and a jump walks one cell per cycle.
// Load runs up to six divisions on the shared bit-serial divider.
// Reset clears control and walker registers at once, not queue or divider data.
// The two-entry queue fills while the walker stalls on an untaken result.
module voxel_ray_traversal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [23:0] start_x_i,
  input  logic signed [23:0] start_y_i,
  input  logic signed [23:0] start_z_i,
  input  logic signed [23:0] end_x_i,
  input  logic signed [23:0] end_y_i,
  input  logic signed [23:0] end_z_i,
  input  logic [6:0]         count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] voxel_x_o,
  output logic signed [15:0] voxel_y_o,
  output logic signed [15:0] voxel_z_o,
  output logic               more_o
);
  import vrt_pkg::*;

  logic req_valid, req_ready;
  req_t req;

  vrt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i,
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i, .count_i,
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  vrt_walk u_walk (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .out_valid_o, .out_ready_i, .voxel_x_o, .voxel_y_o, .voxel_z_o, .more_o
  );
endmodule

/* hw/rtl/vrt_checker.sv */
// Port-level checks for the voxel ray walker, bound to the top level.
module vrt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] voxel_x_o,
  input logic               more_o
);
  // A pending result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(voxel_x_o) && $stable(more_o))
    else $error("result changed while stalled");

  // No result comes straight out of reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result after reset");

  // Results never come back to back: the walker returns to idle between.
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("back-to-back results");

  // Ready is high out of reset.
  a_ready_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_o)
    else $error("not ready after reset");
endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .voxel_x_o, .more_o
);

/* verif/voxel_ray_traversal_tb.sv */
// Self-checking testbench for the voxel ray walker: directed and random requests.
`timescale 1ns / 1ps

module voxel_ray_traversal_tb;
  import vrt_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam logic [63:0] TInf = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOne = 64'd1 << TFracBits;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic               more;
  } voxel_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = '0;
  logic signed [23:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic signed [23:0] end_x_i = '0, end_y_i = '0, end_z_i = '0;
  logic [6:0] count_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] voxel_x_o, voxel_y_o, voxel_z_o;
  logic more_o;

  voxel_ray_traversal dut (.*);

  always #5 clk_i = ~clk_i;

  // Walker state mirror
  logic [15:0] pos [3];
  logic [15:0] goal [3];
  int          dir [3];
  logic [63:0] tnext [3];
  logic [63:0] tstep [3];

  voxel_res_t expected_q[$];
  int  errors = 0;
  longint cycles = 0;
  bit  burst_on = 1'b1;
  int  stall_mode = 0;

  function automatic int cell_of(logic signed [23:0] v);
    return int'(v >>> FracBits);
  endfunction

  function automatic bit walker_at_goal();
    return pos[0] == goal[0] && pos[1] == goal[1] && pos[2] == goal[2];
  endfunction

  function automatic voxel_res_t walker_report(bit more);
    voxel_res_t r;
    r.vx = pos[0];
    r.vy = pos[1];
    r.vz = pos[2];
    r.more = more;
    return r;
  endfunction

  // Move one cell along the axis with the least crossing time
  function automatic void walker_advance();
    int a;
    if (tnext[0] < tnext[1]) a = (tnext[0] < tnext[2]) ? 0 : 2;
    else a = (tnext[1] < tnext[2]) ? 1 : 2;
    if (dir[a] > 0) pos[a] = pos[a] + 16'd1;
    else if (dir[a] < 0) pos[a] = pos[a] - 16'd1;
    if (tnext[a] > TInf - tstep[a]) tnext[a] = TInf;
    else tnext[a] = tnext[a] + tstep[a];
  endfunction

  function automatic voxel_res_t walker_apply(logic [1:0] op, logic signed [23:0] s [3],
                                              logic signed [23:0] e [3], logic [6:0] n);
    voxel_res_t r;
    bit moving;
    int d, mag, steps;
    logic [63:0] num;
    case (op_e'(op))
      OpLoad: begin
        moving = 0;
        for (int a = 0; a < 3; a++) begin
          d = cell_of(e[a]) - cell_of(s[a]);
          pos[a] = 16'(cell_of(s[a]));
          goal[a] = 16'(cell_of(e[a]));
          if (d == 0) begin
            dir[a] = 0;
            tnext[a] = TInf;
            tstep[a] = TInf;
          end else begin
            mag = (d > 0) ? d : -d;
            if (d > 0) num = 64'd256 - s[a][7:0];
            else num = (s[a][7:0] == 0) ? 64'd256 : 64'(s[a][7:0]);
            dir[a] = (d > 0) ? 1 : -1;
            tnext[a] = (num << TFracBits) / (64'(mag) << FracBits);
            tstep[a] = TOne / 64'(mag);
            moving = 1;
          end
        end
        r = walker_report(moving);
      end
      OpStep: begin
        r = walker_report(!walker_at_goal());
        if (r.more) walker_advance();
      end
      OpJump: begin
        if (n == 0 || walker_at_goal()) return walker_report(0);
        steps = (n > MaxJump) ? MaxJump : n;
        for (int i = 0; i < steps; i++) begin
          walker_advance();
          if (walker_at_goal()) return walker_report(0);
        end
        r = walker_report(1);
      end
      default: begin
        for (int a = 0; a < 3; a++) begin
          pos[a] = 16'(cell_of(s[a]));
          if (dir[a] != 0) tnext[a] = TOne;
        end
        r = walker_report(!walker_at_goal());
      end
    endcase
    return r;
  endfunction

  // Send one request, predict its result
  task automatic send_request(logic [1:0] op, logic signed [23:0] sx, sy, sz,
                              logic signed [23:0] ex, ey, ez, logic [6:0] n);
    logic signed [23:0] s [3];
    logic signed [23:0] e [3];
    s = '{sx, sy, sz};
    e = '{ex, ey, ez};
    while (!burst_on) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    op_i <= op;
    start_x_i <= sx; start_y_i <= sy; start_z_i <= sz;
    end_x_i <= ex; end_y_i <= ey; end_z_i <= ez;
    count_i <= n;
    in_valid_i <= 1'b1;
    // ready only changes at the rising edge, so its value here holds at the next one
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    expected_q.push_back(walker_apply(op, s, e, n));
    @(negedge clk_i);
  endtask

  function automatic logic signed [23:0] near_coord();
    return 24'(signed'($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic logic signed [23:0] any_coord();
    return 24'($urandom);
  endfunction

  task automatic test_directed();
    send_request(OpStep, 0, 0, 0, 0, 0, 0, 0);
    send_request(OpJump, 0, 0, 0, 0, 0, 0, 7'd5);
    // degenerate ray
    send_request(OpLoad, 24'sh000180, 0, 0, 24'sh0001FF, 0, 0, 0);
    // extremes of the fields, long ray in x and y
    send_request(OpLoad, 24'sh7FFFFF, 24'sh800000, 24'sh000000,
                 24'sh800000, 24'sh7FFFFF, 24'sh000001, 0);
    send_request(OpStep, 0, 0, 0, 0, 0, 0, 0);
    send_request(OpJump, 0, 0, 0, 0, 0, 0, 7'h7F);
    send_request(OpJump, 0, 0, 0, 0, 0, 0, 7'd0);
    // short ray: jump reaches goal
    send_request(OpLoad, 24'sh000080, 24'sh000040, 24'sh000000,
                 24'sh000380, 24'shFFFE80, 24'sh000200, 0);
    send_request(OpStep, 0, 0, 0, 0, 0, 0, 0);
    send_request(OpJump, 0, 0, 0, 0, 0, 0, 7'd64);
    send_request(OpStep, 0, 0, 0, 0, 0, 0, 0);
    send_request(OpJump, 0, 0, 0, 0, 0, 0, 7'd3);
    // reset position to goal, then away so the goal is unreachable
    send_request(OpReset, 24'sh000300, 24'shFFFE00, 24'sh000200, 0, 0, 0, 0);
    send_request(OpReset, 24'sh7FFF00, 24'sh800000, 24'shFFFFFF, 0, 0, 0, 0);
    send_request(OpJump, 0, 0, 0, 0, 0, 0, 7'd64);
    send_request(OpStep, 0, 0, 0, 0, 0, 0, 0);
    // ties between axes
    send_request(OpLoad, 0, 0, 0, 24'sh000200, 24'sh000200, 24'sh000200, 0);
    send_request(OpJump, 0, 0, 0, 0, 0, 0, 7'd4);
    send_request(OpStep, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(int n_items);
    int k;
    logic signed [23:0] sx, sy, sz;
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        // well-formed: load a ray, then walk it
        sx = near_coord(); sy = near_coord(); sz = near_coord();
        send_request(OpLoad, sx, sy, sz, sx + near_coord(), sy + near_coord(),
                     sz + near_coord(), 7'($urandom));
        k++;
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1)) send_request(OpStep, any_coord(), any_coord(),
                                                 any_coord(), 0, 0, 0, 7'($urandom));
          else if ($urandom_range(0, 5) == 0)
            send_request(OpReset, sx + near_coord(), sy + near_coord(),
                         sz + near_coord(), any_coord(), any_coord(), any_coord(), 0);
          else send_request(OpJump, 0, 0, 0, 0, 0, 0,
                            ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                        : 7'($urandom_range(0, 12)));
          k++;
        end
      end else begin
        send_request(2'($urandom), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord(), 7'($urandom));
        k++;
      end
    end
  endtask

  // Sender bursts and gaps
  always @(negedge clk_i) begin
    if ($urandom_range(0, 15) == 0) burst_on <= ~burst_on;
  end

  // Receiver stall pattern: changes mode now and then
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (cycles[2:0] < 3'd4);
    endcase
  end

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin
    voxel_res_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{voxel_x_o, voxel_y_o, voxel_z_o, more_o};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d more=%0b, actual x=%0d y=%0d z=%0d more=%0b",
                   $time, want.vx, want.vy, want.vz, want.more,
                   got.vx, got.vy, got.vz, got.more);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("voxel_ray_traversal_tb failed");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = '0;
      goal[a] = '0;
      dir[a] = 0;
      tnext[a] = TInf;
      tstep[a] = TInf;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(600);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("voxel_ray_traversal_tb passed");
    end else begin
      $display("voxel_ray_traversal_tb failed");
    end
    $finish;
  end

endmodule
